// ===== hw/rtl/cbq_eq_pkg.sv =====
// shared types, constants and coefficient rom of the cascaded biquad equalizer
`default_nettype none

package cbq_eq_pkg;

    localparam int SECTIONS_DEF = 9;
    localparam int MAX_SEC      = 16;
    localparam int SEC_IDX_W    = 4;
    localparam int FRAC_BITS    = 27;

    localparam logic [31:0] GAIN_RESET = 32'h05A9DF7B;
    localparam logic [31:0] UNITY      = 32'h08000000;

    // columns: b0, b1, b2, a1, a2
    localparam logic [31:0] COEF_ROM [MAX_SEC][5] = '{
        '{32'h07F46AB0, 32'hF05C87C0, 32'h07AFA1BC, 32'hF05CC168, 32'h07A44615},
        '{32'h07ED1CFE, 32'hF03F890A, 32'h07D420FF, 32'hF03F890A, 32'h07C13DFD},
        '{32'h081B095D, 32'hF08F4C0C, 32'h0761E390, 32'hF08F4C0C, 32'h077CECED},
        '{32'h0768EE95, 32'hF3A4F7B5, 32'h067505B4, 32'hF3A4F7B5, 32'h05DDF449},
        '{32'h076FC198, 32'hF6E18719, 32'h040EC81C, 32'hF6E18719, 32'h037E89B4},
        '{32'h073E5C38, 32'hF5A24BD8, 32'h068B40C5, 32'hF5A24BD8, 32'h05C99CFD},
        '{32'h074F07EC, 32'hFAF010E0, 32'h05EB6872, 32'hFAF010E0, 32'h053A705E},
        '{32'h071131FF, 32'h0199A84F, 32'h05314FF6, 32'h0199A84F, 32'h044281F5},
        '{32'h06067A87, 32'hFDFCCCAC, 32'h01272C9B, 32'hFB4CB72E, 32'h01DDBCA0},
        '{UNITY, 32'h0, 32'h0, 32'h0, 32'h0},
        '{UNITY, 32'h0, 32'h0, 32'h0, 32'h0},
        '{UNITY, 32'h0, 32'h0, 32'h0, 32'h0},
        '{UNITY, 32'h0, 32'h0, 32'h0, 32'h0},
        '{UNITY, 32'h0, 32'h0, 32'h0, 32'h0},
        '{UNITY, 32'h0, 32'h0, 32'h0, 32'h0},
        '{UNITY, 32'h0, 32'h0, 32'h0, 32'h0}
    };

    // products of one sample, in issue order within a section
    typedef enum logic [2:0] {
        OP_PRE,
        OP_C0,
        OP_C1,
        OP_C3,
        OP_C2,
        OP_C4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 clear;
        logic                 load;
        logic                 mul_en;
        logic                 mul_hi;
        op_t                  op;
        logic [SEC_IDX_W-1:0] sec;
        logic                 out_load;
    } cmd_t;

    function automatic logic [31:0] coef_lookup(logic [SEC_IDX_W-1:0] sec, op_t op);
        logic [31:0] c;
        case (op)
            OP_C0:   c = COEF_ROM[sec][0];
            OP_C1:   c = COEF_ROM[sec][1];
            OP_C2:   c = COEF_ROM[sec][2];
            OP_C3:   c = COEF_ROM[sec][3];
            OP_C4:   c = COEF_ROM[sec][4];
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cbq_eq_dp.sv =====
// datapath: shared split multiplier, accumulate stage, section delays, output saturation
`default_nettype none

module cbq_eq_dp #(
    parameter int SECTIONS = cbq_eq_pkg::SECTIONS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cbq_eq_pkg::cmd_t    cmd,
    input  wire logic                cfg_wr_en,
    input  wire logic [31:0]         cfg_wr_data,
    input  wire logic signed [15:0]  sample_in,
    output logic signed [15:0]       sample_out
);
    import cbq_eq_pkg::*;

    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    logic [31:0]        pre_gain_reg;
    logic signed [63:0] x_reg;
    logic signed [63:0] y_reg;
    logic signed [63:0] acc_reg;
    logic [63:0]        prod_lo_reg;
    logic [31:0]        prod_hi_reg;
    logic               pend_valid_reg;
    op_t                pend_op_reg;
    logic [SEC_W-1:0]   pend_sec_reg;
    logic signed [63:0] d0_reg [SECTIONS];
    logic signed [63:0] d1_reg [SECTIONS];
    logic [15:0]        out_reg;

    logic [31:0]        coef;
    logic signed [63:0] operand;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_out;
    logic signed [63:0] prod_full;
    logic signed [63:0] term;
    logic signed [63:0] d0_sel;
    logic signed [63:0] d1_sel;
    logic [15:0]        sat_val;

    always_comb begin
        coef = (cmd.op == OP_PRE) ? pre_gain_reg : coef_lookup(cmd.sec, cmd.op);
        if (cmd.op == OP_C1 || cmd.op == OP_C2) begin
            // section input is still in y_reg while its copy to x_reg lands
            operand = (pend_valid_reg && pend_op_reg == OP_C0) ? y_reg : x_reg;
        end else begin
            operand = y_reg;
        end
        mul_a = {coef[31], coef};
        // low half unsigned, high half signed; only the low 32 bits of the high product count
        mul_b = cmd.mul_hi ? {operand[63], operand[63:32]} : {1'b0, operand[31:0]};
        mul_out = mul_a * mul_b;
    end

    always_comb begin
        prod_full = {prod_lo_reg[63:32] + prod_hi_reg, prod_lo_reg[31:0]};
        term = prod_full >>> FRAC_BITS;
        d0_sel = d0_reg[pend_sec_reg];
        d1_sel = d1_reg[pend_sec_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_gain_reg <= GAIN_RESET;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pre_gain_reg <= cfg_wr_data;
            end
            pend_valid_reg <= cmd.mul_en && cmd.mul_hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en && !cmd.mul_hi) begin
            prod_lo_reg <= mul_out[63:0];
        end
        if (cmd.mul_en && cmd.mul_hi) begin
            prod_hi_reg <= mul_out[31:0];
            pend_op_reg <= cmd.op;
            pend_sec_reg <= cmd.sec[SEC_W-1:0];
        end
        if (cmd.load) begin
            y_reg <= {{32{sample_in[15]}}, sample_in, 16'b0};
        end else if (pend_valid_reg) begin
            case (pend_op_reg)
                OP_PRE: y_reg <= term;
                OP_C0: begin
                    x_reg <= y_reg;
                    y_reg <= term + d0_sel;
                end
                OP_C1:   acc_reg <= term + d1_sel;
                OP_C2:   acc_reg <= term;
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            out_reg <= sat_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int i = 0; i < SECTIONS; i++) begin
                d0_reg[i] <= '0;
                d1_reg[i] <= '0;
            end
        end else if (pend_valid_reg) begin
            case (pend_op_reg)
                OP_C3:   d0_reg[pend_sec_reg] <= acc_reg - term;
                OP_C4:   d1_reg[pend_sec_reg] <= acc_reg - term;
                default: ;
            endcase
        end
    end

    // y >>> 16 fits int16 only when bits 63..31 all agree
    always_comb begin
        if (&y_reg[63:31] || ~|y_reg[63:31]) begin
            sat_val = y_reg[31:16];
        end else if (y_reg[63]) begin
            sat_val = 16'h8000;
        end else begin
            sat_val = 16'h7FFF;
        end
    end

    assign sample_out = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cbq_eq_ctrl.sv =====
// controller: handshakes and the product sequence over the sections
`default_nettype none

module cbq_eq_ctrl #(
    parameter int SECTIONS = cbq_eq_pkg::SECTIONS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_action,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output cbq_eq_pkg::cmd_t      cmd
);
    import cbq_eq_pkg::*;

    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic             hi_reg, hi_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic             m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg <= OP_PRE;
            hi_reg <= 1'b0;
            sec_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
            hi_reg <= hi_next;
            sec_reg <= sec_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        hi_next = hi_reg;
        sec_next = sec_reg;
        s_ready = 1'b0;
        cmd = '0;
        cmd.op = op_reg;
        cmd.sec = SEC_IDX_W'(sec_reg);
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action) begin
                        cmd.clear = 1'b1;
                    end else begin
                        cmd.load = 1'b1;
                        state_next = ST_RUN;
                        op_next = OP_PRE;
                        hi_next = 1'b0;
                        sec_next = '0;
                    end
                end
            end
            ST_RUN: begin
                cmd.mul_en = 1'b1;
                cmd.mul_hi = hi_reg;
                hi_next = !hi_reg;
                if (hi_reg) begin
                    case (op_reg)
                        OP_PRE: begin
                            // first b0 product needs the scaled sample in y_reg
                            op_next = OP_C0;
                            state_next = ST_WAIT;
                        end
                        OP_C0:  op_next = OP_C1;
                        OP_C1:  op_next = OP_C3;
                        OP_C3:  op_next = OP_C2;
                        OP_C2:  op_next = OP_C4;
                        OP_C4: begin
                            if (sec_reg == SEC_LAST) begin
                                state_next = ST_DONE;
                            end else begin
                                op_next = OP_C0;
                                sec_next = sec_reg + 1'b1;
                            end
                        end
                        default: op_next = OP_PRE;
                    endcase
                end
            end
            ST_WAIT: begin
                state_next = ST_RUN;
            end
            ST_DONE: begin
                // last combine lands this cycle; it only touches a delay
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_load_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

    a_load_shows_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("result not presented after load");

    a_filter_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_action) |=>
            (state_reg == ST_RUN && op_reg == OP_PRE && !hi_reg && sec_reg == '0))
        else $error("sequence did not start at pre-gain");

    a_sec_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sec_reg <= SEC_LAST)
        else $error("section index out of range");

    a_clear_no_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action) |=> state_reg == ST_IDLE)
        else $error("clear beat started a sequence");

endmodule

`default_nettype wire

// ===== hw/rtl/cascaded_biquad_equalizer.sv =====
// Cascaded biquad equalizer, transposed direct form II, fixed point.
// Input channel s_*: one beat is an action and a 16-bit sample. Action 0 filters
// the sample and yields one beat on m_*; action 1 zeroes all section delays and
// yields nothing. Config: cfg_wr_en/cfg_wr_data load the Q5.27 pre-gain; write it
// only while the block is idle.
// One 33x33 multiplier is shared by all products: each 64x32 product is split into
// a pass over the low and a pass over the high half of the operand, and passes of
// successive products overlap with the accumulate stage; a filter beat runs the
// pre-gain product, then five per section, with a wait state after the pre-gain.
// s_ready is high only in idle; a filter beat is accepted, and the result is
// registered once the products of the last section are done; the next beat
// can be taken the cycle after, so a new sample is not taken before the last
// one is through. A clear beat is taken in idle and leaves the block idle.
// The result sits in an output register, so a stalled receiver does not block
// the next input beat; only a second result waiting to be loaded holds the
// sequencer until m_ready frees the register.
// Reset (aresetn, synchronous, active low) empties the output, zeroes all delays
// and restores the default pre-gain.
`default_nettype none

module cascaded_biquad_equalizer #(
    parameter int SECTIONS = cbq_eq_pkg::SECTIONS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic signed [15:0] s_sample_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_sample_out
);
    import cbq_eq_pkg::*;

    cmd_t cmd;

    cbq_eq_ctrl #(
        .SECTIONS (SECTIONS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd)
    );

    cbq_eq_dp #(
        .SECTIONS (SECTIONS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample_in   (s_sample_in),
        .sample_out  (m_sample_out)
    );

endmodule

`default_nettype wire

// ===== tb/cascaded_biquad_equalizer_tb.sv =====
// testbench for the cascaded biquad equalizer: directed table, then random phases
module cascaded_biquad_equalizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbq_eq_pkg::*;

    localparam int N_SEC        = SECTIONS_DEF;
    localparam int ACTIVE_SEC   = (N_SEC > MAX_SEC) ? MAX_SEC : ((N_SEC < 1) ? 1 : N_SEC);
    localparam int BEAT_LATENCY = 10 * N_SEC + 5;
    localparam int MAX_GAP      = 18;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 120;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_LIMIT  = 2000;

    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef logic signed [63:0] acc_t;

    typedef struct packed {
        logic        set_gain;
        logic [31:0] gain;
        logic        action;
        logic [15:0] sample;
        logic        known;
        logic [15:0] result;
    } vec_t;

    localparam int N_DIRECTED = 25;
    localparam vec_t DIRECTED [N_DIRECTED] = '{
        '{1'b0, 32'h0, ACT_FILTER, 16'h0000, 1'b1, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h7FFF, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h8000, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h0001, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'hFFFF, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_CLEAR,  16'h1234, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h0000, 1'b1, 16'h0000},
        '{1'b0, 32'h0, ACT_CLEAR,  16'h0000, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_CLEAR,  16'hFFFF, 1'b0, 16'h0000},
        // zero gain on empty delays gives silence
        '{1'b1, 32'h0, ACT_FILTER, 16'h7FFF, 1'b1, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h8000, 1'b1, 16'h0000},
        // full-scale gain, products wrap inside the cascade
        '{1'b1, 32'h7FFFFFFF, ACT_FILTER, 16'h7FFF, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h7FFF, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h8000, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h8000, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h7FFF, 1'b0, 16'h0000},
        '{1'b1, 32'h80000000, ACT_FILTER, 16'h8000, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h7FFF, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h8000, 1'b0, 16'h0000},
        '{1'b1, UNITY, ACT_CLEAR,  16'h0000, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h4000, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'hC000, 1'b0, 16'h0000},
        '{1'b0, 32'h0, ACT_FILTER, 16'h0000, 1'b0, 16'h0000}
    };

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               cfg_wr_en    = 1'b0;
    logic [31:0]        cfg_wr_data  = 32'h0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic               s_action     = ACT_FILTER;
    logic signed [15:0] s_sample_in  = 16'sh0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic signed [15:0] m_sample_out;

    logic [31:0]        gain_q = GAIN_RESET;
    acc_t               delay_q [2*MAX_SEC];
    logic signed [15:0] expected_samples [$];
    int                 err_count   = 0;
    int                 cycle_count = 0;
    bit                 quiet       = 1'b0;

    cascaded_biquad_equalizer #(.SECTIONS(N_SEC)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // q5.27 multiply: low 64 bits of the product, arithmetic shift by the fraction
    function automatic acc_t scale_q27(logic [31:0] coef, acc_t x);
        acc_t prod;
        prod = {{32{coef[31]}}, coef} * x;
        return prod >>> FRAC_BITS;
    endfunction

    function automatic void clear_delays();
        for (int i = 0; i < 2*MAX_SEC; i++) delay_q[i] = '0;
    endfunction

    function automatic logic signed [15:0] run_cascade(logic signed [15:0] smp);
        acc_t x;
        acc_t y;
        acc_t v;
        x = acc_t'({{48{smp[15]}}, smp}) << 16;
        x = scale_q27(gain_q, x);
        for (int k = 0; k < ACTIVE_SEC; k++) begin
            y = scale_q27(COEF_ROM[k][0], x) + delay_q[2*k];
            delay_q[2*k] = scale_q27(COEF_ROM[k][1], x) - scale_q27(COEF_ROM[k][3], y)
                           + delay_q[2*k+1];
            delay_q[2*k+1] = scale_q27(COEF_ROM[k][2], x) - scale_q27(COEF_ROM[k][4], y);
            x = y;
        end
        v = x >>> 16;
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    task automatic send_beat(input logic act, input logic [15:0] smp,
                             input logic known, input logic [15:0] result);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_sample_in <= smp;
        do @(posedge aclk); while (!s_ready);
        if (act == ACT_CLEAR) begin
            clear_delays();
        end else begin
            result = known ? result : run_cascade(smp);
            expected_samples.push_back(result);
        end
    endtask

    // only while idle: every result home, then room for a trailing clear beat
    task automatic write_gain(input logic [31:0] value);
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (BEAT_LATENCY) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gain_q = value;
    endtask

    function automatic logic [31:0] pick_gain(int phase);
        if (phase == 0) return GAIN_RESET;
        if (phase == 1) return UNITY;
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return 32'h7FFFFFFF;
            2:       return 32'h80000000;
            3:       return 32'h0;
            4:       return -$urandom_range(0, 2*UNITY);
            default: return $urandom_range(0, 2*UNITY);
        endcase
    endfunction

    initial begin
        int gap;
        wait (aresetn);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (expected_samples.size() == 0) begin
                $error("sample_out: unexpected beat, actual %0d", m_sample_out);
                err_count++;
            end else begin
                logic signed [15:0] want;
                want = expected_samples.pop_front();
                if (m_sample_out !== want) begin
                    $error("sample_out: expected %0d, actual %0d", want, m_sample_out);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int r;
        int waited;
        logic act;
        logic [15:0] smp;
        clear_delays();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].set_gain) begin
                s_valid <= 1'b0;
                write_gain(DIRECTED[i].gain);
            end
            send_beat(DIRECTED[i].action, DIRECTED[i].sample,
                      DIRECTED[i].known, DIRECTED[i].result);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            s_valid <= 1'b0;
            write_gain(pick_gain(p));
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r   = $urandom_range(0, 99);
                act = (r < 5) ? ACT_CLEAR : ACT_FILTER;
                if (r < 15)      smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                else if (r < 50) smp = 16'($urandom_range(0, 511) - 256);
                else             smp = 16'($urandom);
                send_beat(act, smp, 1'b0, 16'h0);
            end
        end
        quiet = 1'b0;

        s_valid <= 1'b0;
        waited = 0;
        while (expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (BEAT_LATENCY) @(posedge aclk);
        if (expected_samples.size() != 0) begin
            $error("sample_out: %0d beats never arrived", expected_samples.size());
            err_count++;
        end
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cbq_eq_pkg.sv
hw/rtl/cbq_eq_dp.sv
hw/rtl/cbq_eq_ctrl.sv
hw/rtl/cascaded_biquad_equalizer.sv
tb/cascaded_biquad_equalizer_tb.sv
